@@ rtl/ssf_pkg.sv @@
// Shared types and constants for the scanline sound sample FIFO.
`default_nettype none

package ssf_pkg;

    // Default sizes of the block.
    localparam int FIFO_DEPTH_DEF      = 128;
    localparam int LINES_PER_FRAME_DEF = 370;
    localparam int RAM_BYTES_DEF       = 131072;

    // Sound buffer offsets below the top of RAM.
    localparam int MAIN_BUF_OFFSET = 'h0300;
    localparam int ALT_BUF_OFFSET  = 'h5F00;

    // Fixed field widths.
    localparam int FETCH_W     = 17;
    localparam int COUNT_W     = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_SOUND_ENABLE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_USE_MAIN_BUFFER = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_AUDIO_ON        = 2'd2;

    // Input item: scanline fetch or sample request.
    typedef struct packed {
        logic        action;
        logic [15:0] ram_word;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic signed [15:0]  sample;
        logic                sample_fresh;
        logic                byte_dropped;
        logic [FETCH_W-1:0]  fetch_address;
        logic [COUNT_W-1:0]  fifo_count;
    } t_out_item;

    // Classified operation handed from the front to the back.
    typedef enum logic [1:0] {
        OP_PUSH,
        OP_POP,
        OP_MUTE
    } t_op_kind;

    typedef struct packed {
        t_op_kind    kind;
        logic [7:0]  data;
    } t_op;

    // Configuration the back needs.
    typedef struct packed {
        logic use_main_buffer;
    } t_cfg;

endpackage

`default_nettype wire

@@ rtl/ssf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ssf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/ssf_front.sv @@
// Front end: configuration registers, item classification and a two-entry op queue.
`default_nettype none

module ssf_front (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire ssf_pkg::t_in_item                 i_in_item,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [ssf_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire logic [ssf_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output ssf_pkg::t_cfg                          o_cfg,
    output logic                                   o_q_valid,
    output ssf_pkg::t_op                           o_q_op,
    input  wire logic                              i_q_take
);

    logic r_sound_enable;
    logic r_use_main_buffer;
    logic r_audio_on;

    ssf_pkg::t_op r_q_op [2];
    logic         r_wr_sel;
    logic         r_rd_sel;
    logic [1:0]   r_q_cnt;

    ssf_pkg::t_op n_op;
    logic         in_accept;
    logic         q_take;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sound_enable    <= 1'b0;
            r_use_main_buffer <= 1'b0;
            r_audio_on        <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ssf_pkg::CFG_SOUND_ENABLE:    r_sound_enable    <= i_cfg_data[0];
                ssf_pkg::CFG_USE_MAIN_BUFFER: r_use_main_buffer <= i_cfg_data[0];
                ssf_pkg::CFG_AUDIO_ON:        r_audio_on        <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg.use_main_buffer = r_use_main_buffer;

    // Classify the incoming item into a push, a pop or a muted request.
    always_comb begin
        n_op.data = 8'h00;
        if (!i_in_item.action) begin
            n_op.kind = ssf_pkg::OP_PUSH;
            if (r_sound_enable) begin
                n_op.data = i_in_item.ram_word[15:8];
            end
        end else if (r_audio_on) begin
            n_op.kind = ssf_pkg::OP_POP;
        end else begin
            n_op.kind = ssf_pkg::OP_MUTE;
        end
    end

    // Two-entry queue toward the back end.
    assign o_in_stall = (r_q_cnt == 2'd2);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_q_cnt != 2'd0);
    assign o_q_op     = r_q_op[r_rd_sel];
    assign q_take     = i_q_take && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_q_op[r_wr_sel] <= n_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_sel <= 1'b0;
            r_rd_sel <= 1'b0;
            r_q_cnt  <= 2'd0;
        end else begin
            if (in_accept) begin
                r_wr_sel <= !r_wr_sel;
            end
            if (q_take) begin
                r_rd_sel <= !r_rd_sel;
            end
            case ({in_accept, q_take})
                2'b10:   r_q_cnt <= r_q_cnt + 2'd1;
                2'b01:   r_q_cnt <= r_q_cnt - 2'd1;
                default: r_q_cnt <= r_q_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/ssf_back.sv @@
// Back end: sample FIFO bookkeeping, byte store, scan position and result register.
`default_nettype none

module ssf_back #(
    parameter int FIFO_DEPTH      = ssf_pkg::FIFO_DEPTH_DEF,
    parameter int LINES_PER_FRAME = ssf_pkg::LINES_PER_FRAME_DEF,
    parameter int RAM_BYTES       = ssf_pkg::RAM_BYTES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_valid,
    input  wire ssf_pkg::t_op       i_q_op,
    output logic                    o_q_take,
    input  wire ssf_pkg::t_cfg      i_cfg,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output ssf_pkg::t_out_item      o_out_item
);

    localparam int PTR_W  = $clog2(FIFO_DEPTH);
    localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
    localparam int LINE_W = $clog2(LINES_PER_FRAME);
    localparam int FW     = ssf_pkg::FETCH_W;
    localparam int CW     = ssf_pkg::COUNT_W;

    localparam logic [31:0] MAIN_BASE_32 = 32'(RAM_BYTES - ssf_pkg::MAIN_BUF_OFFSET);
    localparam logic [31:0] ALT_BASE_32  = 32'(RAM_BYTES - ssf_pkg::ALT_BUF_OFFSET);
    localparam logic [FW-1:0] MAIN_BASE  = MAIN_BASE_32[FW-1:0];
    localparam logic [FW-1:0] ALT_BASE   = ALT_BASE_32[FW-1:0];

    // FIFO and scan bookkeeping.
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [CNT_W-1:0]  r_fill;
    logic [LINE_W-1:0] r_line_next;   // line index after the current one
    logic [15:0]       r_held;

    // Execute stage, waiting for the byte store read.
    logic                r_e_valid;
    ssf_pkg::t_op_kind   r_e_kind;
    logic                r_e_fresh;
    logic                r_e_dropped;
    logic [FW-1:0]       r_e_fetch;
    logic [CW-1:0]       r_e_count;

    // Result register.
    logic                r_o_valid;
    ssf_pkg::t_out_item  r_o_item;

    logic [PTR_W-1:0]  n_rd_ptr;
    logic [PTR_W-1:0]  n_wr_ptr;
    logic [CNT_W-1:0]  n_fill;
    logic [LINE_W-1:0] n_line_next;
    logic              n_fresh;
    logic              n_dropped;
    logic [FW-1:0]     n_fetch;
    logic              ram_we;
    logic              ram_re;
    logic [7:0]        ram_rdata;
    logic              fifo_full;
    logic              fifo_empty;
    logic              e_adv;
    logic              take;
    logic [15:0]       n_sample;

    assign fifo_full  = (r_fill == CNT_W'(FIFO_DEPTH));
    assign fifo_empty = (r_fill == '0);

    // Pipeline advance: the result register frees when the receiver takes it.
    assign e_adv    = r_e_valid && (!r_o_valid || !i_out_stall);
    assign take     = i_q_valid && (!r_e_valid || e_adv);
    assign o_q_take = take;

    // Decide the FIFO update for the op being issued.
    always_comb begin
        n_rd_ptr    = r_rd_ptr;
        n_wr_ptr    = r_wr_ptr;
        n_fill      = r_fill;
        n_line_next = r_line_next;
        n_fresh     = 1'b0;
        n_dropped   = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        case (i_q_op.kind)
            ssf_pkg::OP_PUSH: begin
                if (r_line_next == LINE_W'(LINES_PER_FRAME - 1)) begin
                    n_line_next = '0;
                end else begin
                    n_line_next = r_line_next + LINE_W'(1);
                end
                if (fifo_full) begin
                    n_dropped = 1'b1;
                end else begin
                    ram_we = take;
                    n_fill = r_fill + CNT_W'(1);
                    if (r_wr_ptr == PTR_W'(FIFO_DEPTH - 1)) begin
                        n_wr_ptr = '0;
                    end else begin
                        n_wr_ptr = r_wr_ptr + PTR_W'(1);
                    end
                end
            end
            ssf_pkg::OP_POP: begin
                if (!fifo_empty) begin
                    ram_re  = take;
                    n_fresh = 1'b1;
                    n_fill  = r_fill - CNT_W'(1);
                    if (r_rd_ptr == PTR_W'(FIFO_DEPTH - 1)) begin
                        n_rd_ptr = '0;
                    end else begin
                        n_rd_ptr = r_rd_ptr + PTR_W'(1);
                    end
                end
            end
            default: ;
        endcase
        n_fetch = (i_cfg.use_main_buffer ? MAIN_BASE : ALT_BASE)
                  + FW'({n_line_next, 1'b0});
    end

    ssf_ram #(
        .WIDTH (8),
        .DEPTH (FIFO_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wr_ptr),
        .i_wdata (i_q_op.data),
        .i_re    (ram_re),
        .i_raddr (r_rd_ptr),
        .o_rdata (ram_rdata)
    );

    // Form the sample once the byte store data is back.
    always_comb begin
        case (r_e_kind)
            ssf_pkg::OP_POP: begin
                if (r_e_fresh) begin
                    n_sample = {~ram_rdata[7], ram_rdata[6:0], 8'h00};
                end else begin
                    n_sample = r_held;
                end
            end
            default: n_sample = 16'h0000;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_fill      <= '0;
            r_line_next <= LINE_W'(1);
            r_held      <= 16'h0000;
            r_e_valid   <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            if (take) begin
                r_rd_ptr    <= n_rd_ptr;
                r_wr_ptr    <= n_wr_ptr;
                r_fill      <= n_fill;
                r_line_next <= n_line_next;
                r_e_valid   <= 1'b1;
            end else if (e_adv) begin
                r_e_valid   <= 1'b0;
            end
            if (e_adv) begin
                r_o_valid <= 1'b1;
                if (r_e_fresh) begin
                    r_held <= n_sample;
                end
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload of the execute stage and the result register.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_e_kind    <= i_q_op.kind;
            r_e_fresh   <= n_fresh;
            r_e_dropped <= n_dropped;
            r_e_fetch   <= n_fetch;
            r_e_count   <= CW'(n_fill);
        end
        if (e_adv) begin
            r_o_item.sample        <= $signed(n_sample);
            r_o_item.sample_fresh  <= r_e_fresh;
            r_o_item.byte_dropped  <= r_e_dropped;
            r_o_item.fetch_address <= r_e_fetch;
            r_o_item.fifo_count    <= r_e_count;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_item  = r_o_item;

endmodule

`default_nettype wire

@@ rtl/scanline_sound_sample_fifo_top.sv @@
// Top level of the scanline sound sample FIFO.
//
// The input channel carries one item per handshake: a scanline fetch
// (action 0) that pushes the high byte of ram_word, or zero while sound is
// disabled, or a sample request (action 1) that pops one byte and returns
// it as a signed sample, (byte - 128) << 8. An item is taken on a rising
// edge with i_in_valid high and o_in_stall low; each item gives exactly one
// result on the output channel, taken with o_out_valid high and i_out_stall
// low. Every result also carries the byte address of the word the next
// scanline item must bring.
// Throughput is one item per cycle while the receiver does not stall. An
// item taken passes through the op queue and the FIFO update stage, where
// the byte store read completes, into the result register; it then waits
// there until the receiver takes it. When the receiver stalls, the result
// register holds, the pipeline stops, and the two-entry op queue fills
// before o_in_stall rises. Configuration writes are always ready; the user
// must make them only while no item is in flight; the block does not
// enforce this. Reset empties the FIFO, clears the held sample and the scan
// position, and sets sound_enable 0, use_main_buffer 0, audio_on 1.
`default_nettype none

module scanline_sound_sample_fifo_top #(
    parameter int FIFO_DEPTH      = ssf_pkg::FIFO_DEPTH_DEF,
    parameter int LINES_PER_FRAME = ssf_pkg::LINES_PER_FRAME_DEF,
    parameter int RAM_BYTES       = ssf_pkg::RAM_BYTES_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire ssf_pkg::t_in_item                 i_in_item,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output ssf_pkg::t_out_item                     o_out_item,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [ssf_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire logic [ssf_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    ssf_pkg::t_cfg cfg;
    ssf_pkg::t_op  q_op;
    logic          q_valid;
    logic          q_take;

    // Accept and classify items.
    ssf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_q_valid   (q_valid),
        .o_q_op      (q_op),
        .i_q_take    (q_take)
    );

    // Carry out the FIFO operations and deliver results.
    ssf_back #(
        .FIFO_DEPTH      (FIFO_DEPTH),
        .LINES_PER_FRAME (LINES_PER_FRAME),
        .RAM_BYTES       (RAM_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_op      (q_op),
        .o_q_take    (q_take),
        .i_cfg       (cfg),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

@@ sim/scanline_sound_sample_fifo_top_tb.sv @@
// Self-checking testbench for the scanline sound sample FIFO: directed cases, then random traffic.
module scanline_sound_sample_fifo_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FIFO_DEPTH      = ssf_pkg::FIFO_DEPTH_DEF;
    localparam int LINES_PER_FRAME = ssf_pkg::LINES_PER_FRAME_DEF;
    localparam int RAM_BYTES       = ssf_pkg::RAM_BYTES_DEF;
    localparam int IDX_W           = ssf_pkg::CFG_INDEX_W;

    // Item kinds carried in the action field.
    localparam logic ACT_SCANLINE = 1'b0;
    localparam logic ACT_SAMPLE   = 1'b1;

    // Register index that the block does not decode.
    localparam logic [IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_PHASES = 7;
    localparam int PHASE_ITEMS   = 14;
    localparam int PUSH_PCT [RANDOM_PHASES] = '{50, 80, 20, 60, 95, 5, 50};

    logic                                 i_clk       = 1'b0;
    logic                                 i_rst_n     = 1'b0;
    logic                                 i_in_valid  = 1'b0;
    ssf_pkg::t_in_item                    i_in_item   = '0;
    logic                                 i_out_stall = 1'b0;
    logic                                 i_cfg_valid = 1'b0;
    logic [IDX_W-1:0]                     i_cfg_index = '0;
    logic [ssf_pkg::CFG_DATA_W-1:0]       i_cfg_data  = '0;
    logic                                 o_in_stall;
    logic                                 o_out_valid;
    ssf_pkg::t_out_item                   o_out_item;
    logic                                 o_cfg_ready;

    // Mirror of the block's state and registers.
    logic [7:0]  byte_mirror [FIFO_DEPTH];
    int          mirror_rd;
    int          mirror_wr;
    int          mirror_fill;
    int          mirror_line;
    logic [15:0] mirror_held;
    logic        reg_sound_enable;
    logic        reg_use_main;
    logic        reg_audio_on;

    // Results still owed by the block, oldest first.
    ssf_pkg::t_out_item owed_results [$];

    int errors          = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int fresh_seen      = 0;
    int drops_seen      = 0;
    int frame_wraps     = 0;
    int in_stall_cycles = 0;

    // Receiver control: random stalls, and a long hold counted down by the stall process.
    bit stalls_on  = 1'b1;
    int hold_left  = 0;
    int stall_left = 0;
    int run_left   = 0;

    scanline_sound_sample_fifo_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 50 MHz clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int random_gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 2);
        end else if (r < 94) begin
            return $urandom_range(3, 6);
        end
        return $urandom_range(12, 40);
    endfunction

    // Applies one item to the mirror state and returns the result the block must give.
    function automatic ssf_pkg::t_out_item predict_sound_result(ssf_pkg::t_in_item it);
        ssf_pkg::t_out_item res;
        int                 next_line;
        int                 base;
        logic [7:0]         pushed;
        res = '0;
        if (it.action == ACT_SCANLINE) begin
            mirror_line = mirror_line + 1;
            if (mirror_line >= LINES_PER_FRAME) begin
                mirror_line = 0;
                frame_wraps++;
            end
            if (mirror_fill >= FIFO_DEPTH) begin
                res.byte_dropped = 1'b1;
            end else begin
                pushed = reg_sound_enable ? it.ram_word[15:8] : 8'h00;
                byte_mirror[mirror_wr] = pushed;
                mirror_wr = (mirror_wr + 1) % FIFO_DEPTH;
                mirror_fill++;
            end
        end else if (reg_audio_on) begin
            // An empty FIFO repeats the last popped sample.
            if (mirror_fill > 0) begin
                mirror_held = {byte_mirror[mirror_rd] ^ 8'h80, 8'h00};
                mirror_rd = (mirror_rd + 1) % FIFO_DEPTH;
                mirror_fill--;
                res.sample_fresh = 1'b1;
            end
            res.sample = mirror_held;
        end
        next_line = (mirror_line + 1 >= LINES_PER_FRAME) ? 0 : mirror_line + 1;
        base = RAM_BYTES - (reg_use_main ? ssf_pkg::MAIN_BUF_OFFSET : ssf_pkg::ALT_BUF_OFFSET);
        res.fetch_address = ssf_pkg::FETCH_W'(base + 2 * next_line);
        res.fifo_count = ssf_pkg::COUNT_W'(mirror_fill);
        return res;
    endfunction

    task automatic check_field(string name, logic [16:0] want, logic [16:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        ssf_pkg::t_out_item want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_stall) begin
                in_stall_cycles++;
            end
            if (o_out_valid && !i_out_stall) begin
                if (owed_results.size() == 0) begin
                    errors++;
                    $display("%0t ns: unexpected result, expected none, actual %h",
                             $time, o_out_item);
                end else begin
                    want = owed_results.pop_front();
                    check_field("sample", 17'($unsigned(want.sample)),
                                17'($unsigned(o_out_item.sample)));
                    check_field("sample_fresh", 17'(want.sample_fresh),
                                17'(o_out_item.sample_fresh));
                    check_field("byte_dropped", 17'(want.byte_dropped),
                                17'(o_out_item.byte_dropped));
                    check_field("fetch_address", want.fetch_address,
                                o_out_item.fetch_address);
                    check_field("fifo_count", 17'(want.fifo_count),
                                17'(o_out_item.fifo_count));
                    results_checked++;
                    if (want.sample_fresh) begin
                        fresh_seen++;
                    end
                    if (want.byte_dropped) begin
                        drops_seen++;
                    end
                end
            end
        end
    end

    // Receiver stall pattern.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else if (!stalls_on) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else if (run_left > 0) begin
            i_out_stall <= 1'b0;
            run_left--;
        end else begin
            i_out_stall <= 1'b0;
            run_left = $urandom_range(0, 8);
            stall_left = random_gap_length();
        end
    end

    // Offers one item and waits until it is taken; valid stays high for a following item.
    task automatic send_item(logic act, logic [15:0] word);
        ssf_pkg::t_in_item it;
        it.action = act;
        it.ram_word = word;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (o_in_stall);
        owed_results.push_back(predict_sound_result(it));
        items_sent++;
    endtask

    task automatic pause_sender(int cycles);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // Random item with the given share of scanlines, and optional gaps before it.
    task automatic send_random_item(int push_pct, bit gaps);
        logic act;
        act = ($urandom_range(0, 99) < push_pct) ? ACT_SCANLINE : ACT_SAMPLE;
        if (gaps && $urandom_range(0, 99) < 35) begin
            pause_sender(random_gap_length());
        end
        send_item(act, 16'($urandom));
    endtask

    // Stops offering and lets every owed result drain out of the block.
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (owed_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(logic [IDX_W-1:0] idx, logic val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            ssf_pkg::CFG_SOUND_ENABLE:    reg_sound_enable = val;
            ssf_pkg::CFG_USE_MAIN_BUFFER: reg_use_main = val;
            ssf_pkg::CFG_AUDIO_ON:        reg_audio_on = val;
            default:                      ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Out of reset: empty pop gives zero, and disabled sound pushes zero bytes.
    task automatic test_power_on_defaults();
        send_item(ACT_SAMPLE, 16'hFFFF);
        send_item(ACT_SCANLINE, 16'hFFFF);
        send_item(ACT_SAMPLE, 16'h0000);
        send_item(ACT_SAMPLE, 16'h0000);
        wait_idle();
    endtask

    // Both ends of the byte range and the midpoint, from the main buffer.
    task automatic test_byte_extremes();
        write_register(ssf_pkg::CFG_SOUND_ENABLE, 1'b1);
        write_register(ssf_pkg::CFG_USE_MAIN_BUFFER, 1'b1);
        send_item(ACT_SCANLINE, 16'hFFFF);
        send_item(ACT_SCANLINE, 16'h0000);
        send_item(ACT_SCANLINE, 16'h80AA);
        send_item(ACT_SCANLINE, 16'h7F55);
        repeat (5) send_item(ACT_SAMPLE, 16'h0000);
        wait_idle();
    endtask

    // Muted requests give zero and keep the FIFO and the held sample as they are.
    task automatic test_audio_mute();
        write_register(ssf_pkg::CFG_USE_MAIN_BUFFER, 1'b0);
        write_register(CFG_UNUSED, 1'b1);
        send_item(ACT_SCANLINE, 16'h1234);
        wait_idle();
        write_register(ssf_pkg::CFG_AUDIO_ON, 1'b0);
        send_item(ACT_SAMPLE, 16'hFFFF);
        send_item(ACT_SAMPLE, 16'h0000);
        send_item(ACT_SCANLINE, 16'hC3C3);
        wait_idle();
        write_register(ssf_pkg::CFG_AUDIO_ON, 1'b1);
        repeat (3) send_item(ACT_SAMPLE, 16'h0000);
        wait_idle();
    endtask

    // Overfill so bytes are dropped, then drain past empty.
    task automatic test_fifo_full();
        repeat (FIFO_DEPTH + 2) send_item(ACT_SCANLINE, 16'($urandom));
        repeat (FIFO_DEPTH + 1) send_item(ACT_SAMPLE, 16'($urandom));
        wait_idle();
    endtask

    // Run the scan index through its wrap, with a pop after every fourth scanline.
    task automatic test_frame_wrap();
        int lines_left;
        lines_left = LINES_PER_FRAME - mirror_line + 2;
        for (int i = 0; i < lines_left; i++) begin
            send_item(ACT_SCANLINE, 16'($urandom));
            if (i % 4 == 3) begin
                send_item(ACT_SAMPLE, 16'($urandom));
            end
        end
        wait_idle();
    endtask

    // The receiver holds off for a long stretch while items keep coming.
    task automatic test_backpressure();
        stalls_on = 1'b0;
        hold_left = 150;
        repeat (40) send_random_item(50, 1'b0);
        wait_idle();
        stalls_on = 1'b1;
    endtask

    // Phases of random items, each under its own register setting and traffic shape.
    task automatic test_random_traffic();
        bit gaps;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            gaps = (ph % 3 != 2);
            stalls_on = gaps;
            write_register(ssf_pkg::CFG_SOUND_ENABLE,
                           (ph == 0) ? 1'b1 : 1'($urandom_range(0, 1)));
            write_register(ssf_pkg::CFG_USE_MAIN_BUFFER, 1'($urandom_range(0, 1)));
            write_register(ssf_pkg::CFG_AUDIO_ON, ($urandom_range(0, 4) != 0));
            repeat (PHASE_ITEMS) send_random_item(PUSH_PCT[ph], gaps);
            wait_idle();
        end
        stalls_on = 1'b1;
    endtask

    // Test sequence.
    initial begin
        mirror_rd = 0;
        mirror_wr = 0;
        mirror_fill = 0;
        mirror_line = 0;
        mirror_held = 16'h0000;
        reg_sound_enable = 1'b0;
        reg_use_main = 1'b0;
        reg_audio_on = 1'b1;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_power_on_defaults();
        test_byte_extremes();
        test_audio_mute();
        test_fifo_full();
        test_frame_wrap();
        test_backpressure();
        test_random_traffic();
        wait_idle();

        $display("Checked %0d results from %0d items: %0d fresh samples, %0d dropped bytes.",
                 results_checked, items_sent, fresh_seen, drops_seen);
        $display("Scan index wrapped %0d times; input was stalled for %0d cycles.",
                 frame_wraps, in_stall_cycles);
        if (errors == 0) begin
            $display("scanline_sound_sample_fifo_top regression: pass");
        end else begin
            $display("scanline_sound_sample_fifo_top regression: fail");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #20_000_000;
        $display("%0t ns: timeout with %0d results outstanding", $time, owed_results.size());
        $display("scanline_sound_sample_fifo_top regression: fail");
        $finish;
    end

endmodule
